FILE: rtl/b64e_pkg.sv
// Shared types, codes and the character map of the Base64 stream encoder.
`timescale 1ns / 1ps
`default_nettype none
package b64e_pkg;

   localparam logic [1:0] OP_DATA   = 2'd0;
   localparam logic [1:0] OP_FINISH = 2'd1;
   localparam logic [1:0] OP_ABORT  = 2'd2;

   localparam logic [1:0] CSR_SYMBOL_62 = 2'd0;
   localparam logic [1:0] CSR_SYMBOL_63 = 2'd1;
   localparam logic [1:0] CSR_PAD_CHAR  = 2'd2;

   localparam logic [7:0] SYMBOL_62_RESET = 8'd43;
   localparam logic [7:0] SYMBOL_63_RESET = 8'd47;
   localparam logic [7:0] PAD_CHAR_RESET  = 8'd61;

   localparam int RUN_DEPTH = 3;

   // characters produced by one input word, entry 0 goes out first
   typedef struct packed {
      logic [RUN_DEPTH-1:0][7:0] chars;
      logic [1:0]                count;
      logic                      finish;
   } run_type;

   function automatic logic [7:0] b64e_to_char(input logic [5:0] v,
                                                input logic [7:0] s62,
                                                input logic [7:0] s63);
      logic [7:0] v8;
      v8 = {2'b00, v};
      if (v < 6'd26)      return 8'd65 + v8;
      else if (v < 6'd52) return 8'd71 + v8;
      else if (v < 6'd62) return v8 - 8'd4;
      else if (v == 6'd62) return s62;
      else                return s63;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/base64_stream_encoder_top.sv
// Top level of the streaming Base64 encoder.
// Usage:
//   req_ channel: one word per accepted item, req_operation selects data byte,
//   finish (flush leftover bits and pad) or abort (clear the group phase).
//   rsp_ channel: one character per word; rsp_last_of_run marks the last
//   character caused by an input word, rsp_message_end the last of a flush.
//   csr_ port: write-only symbol 62, symbol 63 and pad character registers;
//   write them only while the encoder is idle. A zero pad character turns
//   padding off.
// Path: the run buffer loads at the accepting edge, and the output register
//   loads from it whenever rsp_valid is low or rsp_ready is high.
// Throughput: one character per cycle on the result side while rsp_ready
//   is high, set by the single output register; a data byte yields one or
//   two characters, a finish up to three, an abort or an empty finish none;
//   three bytes yield four characters.
// Reset: phase and carry clear, registers return to '+', '/' and '='.
// Stall: while rsp_ready is low the output character holds; the run buffer
//   keeps the rest of the current word and req_ready drops until it drains.
`timescale 1ns / 1ps
`default_nettype none
module base64_stream_encoder_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_operation,
   input  wire logic [7:0] req_data_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_char,
   output logic            rsp_last_of_run,
   output logic            rsp_message_end,
   input  wire logic       csr_write_en,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_wdata
);
   import b64e_pkg::*;

   run_type run;
   logic    accept;

   assign accept = req_valid && req_ready;

   b64e_encode u_encode (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .operation    (req_operation),
      .data_byte    (req_data_byte),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .run          (run)
   );

   b64e_serial u_serial (
      .clock     (clock),
      .reset     (reset),
      .load      (accept && (run.count != 2'd0)),
      .run       (run),
      .take_ok   (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_char  (rsp_out_char),
      .out_last  (rsp_last_of_run),
      .out_end   (rsp_message_end)
   );

endmodule
`default_nettype wire

FILE: rtl/b64e_encode.sv
// Phase tracking, symbol registers and character generation for one input word.
`timescale 1ns / 1ps
`default_nettype none
module b64e_encode (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic [1:0]         operation,
   input  wire logic [7:0]         data_byte,
   input  wire logic               csr_write_en,
   input  wire logic [1:0]         csr_index,
   input  wire logic [7:0]         csr_wdata,
   output b64e_pkg::run_type       run
);
   import b64e_pkg::*;

   logic [1:0] phase_ff, phase_in;
   logic [3:0] carry_ff, carry_in;
   logic [7:0] symbol_62_ff, symbol_63_ff, pad_char_ff;
   logic       pad_on;

   assign pad_on = (pad_char_ff != 8'd0);

   always_comb begin
      phase_in   = phase_ff;
      carry_in   = carry_ff;
      run        = '0;
      run.chars[1] = pad_char_ff;
      run.chars[2] = pad_char_ff;
      case (operation)
         OP_DATA: begin
            carry_in = data_byte[3:0];
            case (phase_ff)
               2'd1: begin
                  run.chars[0] = b64e_to_char({carry_ff[1:0], data_byte[7:4]},
                                              symbol_62_ff, symbol_63_ff);
                  run.count = 2'd1;
                  phase_in  = 2'd2;
               end
               2'd2: begin
                  run.chars[0] = b64e_to_char({carry_ff, data_byte[7:6]},
                                              symbol_62_ff, symbol_63_ff);
                  run.chars[1] = b64e_to_char(data_byte[5:0], symbol_62_ff, symbol_63_ff);
                  run.count = 2'd2;
                  phase_in  = 2'd0;
               end
               default: begin
                  run.chars[0] = b64e_to_char(data_byte[7:2], symbol_62_ff, symbol_63_ff);
                  run.count = 2'd1;
                  phase_in  = 2'd1;
               end
            endcase
         end
         OP_FINISH: begin
            run.finish = 1'b1;
            phase_in   = 2'd0;
            case (phase_ff)
               2'd1: begin
                  run.chars[0] = b64e_to_char({carry_ff[1:0], 4'b0000},
                                              symbol_62_ff, symbol_63_ff);
                  run.count = pad_on ? 2'd3 : 2'd1;
               end
               2'd2: begin
                  run.chars[0] = b64e_to_char({carry_ff, 2'b00},
                                              symbol_62_ff, symbol_63_ff);
                  run.count = pad_on ? 2'd2 : 2'd1;
               end
               default: begin
                  run.count = 2'd0;
               end
            endcase
         end
         OP_ABORT: begin
            phase_in = 2'd0;
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 2'd0;
         carry_ff <= 4'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         carry_ff <= carry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         symbol_62_ff <= SYMBOL_62_RESET;
         symbol_63_ff <= SYMBOL_63_RESET;
         pad_char_ff  <= PAD_CHAR_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SYMBOL_62: symbol_62_ff <= csr_wdata;
            CSR_SYMBOL_63: symbol_63_ff <= csr_wdata;
            CSR_PAD_CHAR:  pad_char_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

endmodule
`default_nettype wire

FILE: rtl/b64e_serial.sv
// Run buffer and output register: a word's characters one per cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none
module b64e_serial (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          load,
   input  b64e_pkg::run_type  run,
   output logic               take_ok,
   output logic               out_valid,
   input  wire logic          out_ready,
   output logic [7:0]         out_char,
   output logic               out_last,
   output logic               out_end
);
   import b64e_pkg::*;

   run_type    run_ff, run_in;
   logic       valid_ff, valid_in;
   logic [7:0] char_ff;
   logic       last_ff, end_ff;
   logic       pop;

   assign pop     = (run_ff.count != 2'd0) && (!valid_ff || out_ready);
   assign take_ok = (run_ff.count == 2'd0) || ((run_ff.count == 2'd1) && pop);

   always_comb begin
      run_in = run_ff;
      if (load) begin
         run_in = run;
      end else if (pop) begin
         run_in.chars[0] = run_ff.chars[1];
         run_in.chars[1] = run_ff.chars[2];
         run_in.count    = run_ff.count - 2'd1;
      end
      valid_in = pop || (valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff.count <= 2'd0;
         valid_ff     <= 1'b0;
      end else begin
         run_ff.count <= run_in.count;
         valid_ff     <= valid_in;
      end
      run_ff.chars  <= run_in.chars;
      run_ff.finish <= run_in.finish;
      if (pop) begin
         char_ff <= run_ff.chars[0];
         last_ff <= (run_ff.count == 2'd1);
         end_ff  <= (run_ff.count == 2'd1) && run_ff.finish;
      end
   end

   assign out_valid = valid_ff;
   assign out_char  = char_ff;
   assign out_last  = last_ff;
   assign out_end   = end_ff;

endmodule
`default_nettype wire

FILE: rtl/b64e_checker.sv
// Port-level assertions for the Base64 stream encoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module b64e_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic [1:0] req_operation,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_char,
   input wire logic       rsp_last_of_run,
   input wire logic       rsp_message_end
);
   import b64e_pkg::*;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char))
      else $error("stalled character changed");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_message_end |-> rsp_last_of_run)
      else $error("message end without last of run");

   a_data_yields: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_operation == OP_DATA) |-> ##2 rsp_valid)
      else $error("data word produced no character");

endmodule

bind base64_stream_encoder_top b64e_checker u_b64e_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_operation   (req_operation),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_char    (rsp_out_char),
   .rsp_last_of_run (rsp_last_of_run),
   .rsp_message_end (rsp_message_end)
);
`default_nettype wire
